### rtl/midi_controlled_wave_oscillator_core_assert.svh
// Assertion macros shared by the oscillator checker.
`ifndef MIDI_CONTROLLED_WAVE_OSCILLATOR_CORE_ASSERT_SVH
`define MIDI_CONTROLLED_WAVE_OSCILLATOR_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define MCWO_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define MCWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check what the cycle after a reset cycle shows.
`define MCWO_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### rtl/mcwo_pkg.sv
// Package: types and constants of the MIDI controlled wave oscillator.
`default_nettype none

package mcwo_pkg;

  localparam int unsigned SAMPLE_RATE = 48000;
  localparam int unsigned SINE_DEPTH  = 1024;
  localparam int unsigned SINE_KEEP   = $clog2(SINE_DEPTH);
  localparam logic [15:0] SINE_MASK   = 16'(32'hFFFF << (16 - SINE_KEEP));

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] STATUS_CC     = 8'hB0;
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;

  localparam logic [3:0] CC_WAVE   = 4'd1;
  localparam logic [3:0] CC_PULSE  = 4'd2;
  localparam logic [3:0] CC_DEPTH  = 4'd3;
  localparam logic [3:0] CC_VOLUME = 4'd4;

  // Smallest controller values that give wave codes one and two (value*3/127).
  localparam logic [6:0] WAVE_STEP1 = 7'((127 + 2) / 3);
  localparam logic [6:0] WAVE_STEP2 = 7'((2 * 127 + 2) / 3);
  localparam logic [6:0] CTRL_MAX   = 7'd127;

  localparam logic [6:0] NOTE_RESET   = 7'd69;
  localparam logic [6:0] PULSE_RESET  = 7'd64;
  localparam logic [6:0] VOLUME_RESET = 7'd64;

  // Octave-zero note frequencies, Q16.16 Hz.
  localparam logic [19:0] OCTAVE_HZ_Q16 [12] = '{
    20'd535809, 20'd567670, 20'd601425, 20'd637188, 20'd675077, 20'd715219,
    20'd757749, 20'd802807, 20'd850544, 20'd901120, 20'd954703, 20'd1011473
  };

  localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  // floor(2^24 / 127): reciprocal for the divide by 127.
  localparam logic [17:0] RECIP_127 = 18'd132104;
  localparam int unsigned RECIP_SHIFT = 24;

  typedef enum logic [1:0] {
    WAVE_SINE,
    WAVE_TRI,
    WAVE_SAW,
    WAVE_SQUARE
  } wave_t;

  typedef enum logic [2:0] {
    OP_WAVE,
    OP_PULSE,
    OP_DEPTH,
    OP_VOLUME,
    OP_NOTE,
    OP_PROGRAM,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] val;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZZ,
    ST_T1,
    ST_T2,
    ST_TR,
    ST_TQ,
    ST_RING,
    ST_BLEND,
    ST_DIVA,
    ST_DIVB,
    ST_VOL,
    ST_OUT
  } seq_state_t;

endpackage

`default_nettype wire

### rtl/midi_controlled_wave_oscillator_core.sv
// Top level: MIDI controlled direct-digital multi-waveform oscillator.
//
//   channel   direction  handshake        payload
//   input     in         push / full      action, status_byte, data_one, data_two
//   result    out        empty / pop      sample_out (signed Q1.15)
//
// The decoder classifies each transaction in the cycle it is accepted and drops
// MIDI messages that change nothing; a four-entry command queue holds the rest.
// The sequencer takes one command at a time and applies a MIDI command in its idle step.
// For a sample, one shared 32x19 multiplier runs the sine polynomial (five steps
// per sine, up to two sines), the ring blend and the divide-by-127 steps for
// blend and volume, one product per cycle.
// Synchronous reset empties both queues and restores the settings.
// A stalled result holds the sequencer in its output step; the command queue
// keeps taking transactions until it fills.
`default_nettype none

module midi_controlled_wave_oscillator_core #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic [7:0]         status_byte,
  input  logic [6:0]         data_one,
  input  logic [6:0]         data_two,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample_out
);

  logic            q_wr;
  mcwo_pkg::item_t q_wr_entry;
  logic            q_rd;
  mcwo_pkg::item_t q_rd_entry;
  logic            q_nempty;

  // Classify each accepted transaction; drop MIDI messages with no effect.
  mcwo_front u_front (
    .push        (push),
    .full        (full),
    .action      (action),
    .status_byte (status_byte),
    .data_one    (data_one),
    .data_two    (data_two),
    .wr          (q_wr),
    .entry       (q_wr_entry)
  );

  // Hold commands while the sequencer works on a sample.
  mcwo_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_entry (q_wr_entry),
    .rd       (q_rd),
    .rd_entry (q_rd_entry),
    .nempty   (q_nempty),
    .full     (full)
  );

  // Apply settings in order and compute samples; advance phases per sample.
  mcwo_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nempty   (q_nempty),
    .q_entry    (q_rd_entry),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .sample_out (sample_out)
  );

endmodule

`default_nettype wire

### rtl/mcwo_queue.sv
// Command queue between the decoder and the sample sequencer.
`default_nettype none

module mcwo_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mcwo_pkg::item_t  wr_entry,
  input  logic             rd,
  output mcwo_pkg::item_t  rd_entry,
  output logic             nempty,
  output logic             full
);

  mcwo_pkg::item_t                   slots [mcwo_pkg::QDEPTH];
  logic [mcwo_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mcwo_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mcwo_pkg::QCNT_W-1:0]       count;

  assign nempty   = (count != '0);
  assign full     = (count == mcwo_pkg::QCNT_W'(mcwo_pkg::QDEPTH));
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/mcwo_front.sv
// Front end: accept items and classify them into queue commands.
`default_nettype none

module mcwo_front (
  input  logic             push,
  input  logic             full,
  input  logic             action,
  input  logic [7:0]       status_byte,
  input  logic [6:0]       data_one,
  input  logic [6:0]       data_two,
  output logic             wr,
  output mcwo_pkg::item_t  entry
);

  logic          accept;
  mcwo_pkg::wave_t wave_code;

  assign accept = push && !full;

  // value*3/127, truncated
  always_comb begin
    if (data_two == mcwo_pkg::CTRL_MAX) begin
      wave_code = mcwo_pkg::WAVE_SQUARE;
    end else if (data_two >= mcwo_pkg::WAVE_STEP2) begin
      wave_code = mcwo_pkg::WAVE_SAW;
    end else if (data_two >= mcwo_pkg::WAVE_STEP1) begin
      wave_code = mcwo_pkg::WAVE_TRI;
    end else begin
      wave_code = mcwo_pkg::WAVE_SINE;
    end
  end

  // Drop messages that change nothing.
  always_comb begin
    wr        = 1'b0;
    entry.op  = mcwo_pkg::OP_SAMPLE;
    entry.val = data_one;
    if (action) begin
      wr = accept;
    end else if (status_byte == mcwo_pkg::STATUS_CC) begin
      entry.val = data_two;
      case (data_one[3:0])
        mcwo_pkg::CC_WAVE: begin
          wr        = accept;
          entry.op  = mcwo_pkg::OP_WAVE;
          entry.val = {5'b0, wave_code};
        end
        mcwo_pkg::CC_PULSE: begin
          wr       = accept;
          entry.op = mcwo_pkg::OP_PULSE;
        end
        mcwo_pkg::CC_DEPTH: begin
          wr       = accept;
          entry.op = mcwo_pkg::OP_DEPTH;
        end
        mcwo_pkg::CC_VOLUME: begin
          wr       = accept;
          entry.op = mcwo_pkg::OP_VOLUME;
        end
        default: wr = 1'b0;
      endcase
    end else if (status_byte[7:4] == mcwo_pkg::TYPE_NOTE_OFF) begin
      wr       = accept;
      entry.op = mcwo_pkg::OP_NOTE;
    end else if (status_byte[7:4] == mcwo_pkg::TYPE_PROGRAM) begin
      wr       = accept;
      entry.op = mcwo_pkg::OP_PROGRAM;
    end
  end

endmodule

`default_nettype wire

### rtl/mcwo_back.sv
// Back end: settings, phase accumulators and the shared-multiplier sample sequencer.
`default_nettype none

module mcwo_back #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_nempty,
  input  mcwo_pkg::item_t     q_entry,
  output logic                q_rd,
  input  logic                pop,
  output logic                empty,
  output logic signed [15:0]  sample_out
);

  typedef struct packed {
    logic [16:0] z;
    logic        neg;
  } fold_t;

  function automatic fold_t sine_fold(input logic [15:0] f);
    logic [15:0] a;
    fold_t       r;
    a     = f & mcwo_pkg::SINE_MASK;
    r.z   = {1'b0, a[13:0], 2'b00};
    if (a[14]) begin
      r.z = 17'h10000 - r.z;
    end
    r.neg = a[15];
    return r;
  endfunction

  // Phase increments per note, worked out at elaboration.
  logic [PHASE_BITS-1:0] inc_tab  [128];
  logic [PHASE_BITS-1:0] minc_tab [128];

  for (genvar g = 0; g < 128; g++) begin : g_inc
    localparam logic [63:0] BASE = 64'(mcwo_pkg::OCTAVE_HZ_Q16[g % 12]);
    localparam int unsigned SH = g / 12 + PHASE_BITS - 16;
    localparam logic [63:0] INC =
      ((BASE << SH) + 64'(mcwo_pkg::SAMPLE_RATE / 2)) / 64'(mcwo_pkg::SAMPLE_RATE);
    localparam logic [63:0] MINC =
      (((INC >> 16) * mcwo_pkg::INV_TWO_PI_Q32)
       + (((INC & 64'hFFFF) * mcwo_pkg::INV_TWO_PI_Q32) >> 16)) >> 16;
    assign inc_tab[g]  = INC[PHASE_BITS-1:0];
    assign minc_tab[g] = MINC[PHASE_BITS-1:0];
  end

  mcwo_pkg::seq_state_t state, state_next;

  logic [PHASE_BITS-1:0] main_phase;
  logic [PHASE_BITS-1:0] mod_phase;
  logic [6:0]            note_number;
  mcwo_pkg::wave_t       wave_select;
  logic [6:0]            pulse_level;
  logic [6:0]            mod_depth;
  logic [6:0]            volume_level;
  logic [6:0]            program_number;

  logic signed [50:0] prod;
  logic [16:0]        z_reg;
  logic [16:0]        z2_reg;
  logic               neg_reg;
  logic               sine_sel;
  logic               div_sel;
  logic signed [17:0] s_reg;
  logic signed [16:0] m_reg;
  logic [23:0]        ax_reg;
  logic               xneg_reg;
  logic               out_valid;

  logic [15:0]        f_main;
  fold_t              fold_main;
  fold_t              fold_mod;
  logic               wave_is_sine;
  logic signed [17:0] wave_val;
  logic [22:0]        sq_lhs;
  logic [31:0]        r_sum;
  logic [16:0]        q_raw;
  logic [15:0]        q_clip;
  logic signed [16:0] sine_val;
  logic [17:0]        p_val;
  logic signed [18:0] diff;
  logic [24:0]        x_val;
  logic [24:0]        ax_full;
  logic [17:0]        q0;
  logic [24:0]        rem;
  logic [17:0]        q_fix;
  logic signed [18:0] div_res;
  logic signed [18:0] blend_sum;
  logic signed [17:0] vol_sat;
  logic signed [31:0] mul_a;
  logic signed [18:0] mul_b;
  logic               out_load;

  assign f_main       = main_phase[PHASE_BITS-1 -: 16];
  assign fold_main    = sine_fold(f_main);
  assign fold_mod     = sine_fold(mod_phase[PHASE_BITS-1 -: 16]);
  assign wave_is_sine = (program_number == 7'd0) && (wave_select == mcwo_pkg::WAVE_SINE);
  assign sq_lhs       = {f_main, 7'b0} - {7'b0, f_main};

  always_comb begin
    if (program_number != 7'd0) begin
      wave_val = '0;
    end else begin
      case (wave_select)
        mcwo_pkg::WAVE_TRI:
          wave_val = f_main[15] ? (18'sd32768 - $signed({2'b0, f_main}))
                                : $signed({2'b0, f_main});
        mcwo_pkg::WAVE_SAW:
          wave_val = $signed({2'b0, f_main}) - 18'sd32768;
        mcwo_pkg::WAVE_SQUARE:
          wave_val = (sq_lhs > {pulse_level, 16'b0}) ? 18'sd32767 : -18'sd32768;
        default:
          wave_val = '0;
      endcase
    end
  end

  // Round the polynomial to Q1.15, clip and restore the sign.
  assign r_sum    = {1'b0, prod[46:16]} + 32'd16384;
  assign q_raw    = r_sum[31:15];
  assign q_clip   = (q_raw > 17'd32767) ? 16'd32767 : q_raw[15:0];
  assign sine_val = neg_reg ? $signed(17'd0 - {1'b0, q_clip}) : $signed({1'b0, q_clip});

  // Ring product floor-shifted back to Q1.15, minus the dry sample.
  assign p_val = prod[32:15];
  assign diff  = $signed({p_val[17], p_val}) - $signed({s_reg[17], s_reg});

  // Truncating divide by 127: magnitude times reciprocal, then one correction.
  assign x_val     = prod[24:0];
  assign ax_full   = x_val[24] ? (25'd0 - x_val) : x_val;
  assign q0        = prod[41:24];
  assign rem       = {1'b0, ax_reg} - ({q0, 7'b0} - {7'b0, q0});
  assign q_fix     = (rem >= 25'd127) ? (q0 + 18'd1) : q0;
  assign div_res   = xneg_reg ? $signed(19'd0 - {1'b0, q_fix}) : $signed({1'b0, q_fix});
  assign blend_sum = $signed({s_reg[17], s_reg}) + div_res;

  always_comb begin
    if (div_res > 19'sd32767) begin
      vol_sat = 18'sd32767;
    end else if (div_res < -19'sd32768) begin
      vol_sat = -18'sd32768;
    end else begin
      vol_sat = div_res[17:0];
    end
  end

  // Operand select for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      mcwo_pkg::ST_ZZ: begin
        mul_a = {15'b0, z_reg};
        mul_b = {2'b0, z_reg};
      end
      mcwo_pkg::ST_T1: begin
        mul_a = {5'b0, mcwo_pkg::SIN_C};
        mul_b = {2'b0, prod[32:16]};
      end
      mcwo_pkg::ST_T2: begin
        mul_a = {2'b0, mcwo_pkg::SIN_B - {3'b0, prod[42:16]}};
        mul_b = {2'b0, z2_reg};
      end
      mcwo_pkg::ST_TR: begin
        mul_a = {1'b0, mcwo_pkg::SIN_A - {1'b0, prod[45:16]}};
        mul_b = {2'b0, z_reg};
      end
      mcwo_pkg::ST_RING: begin
        mul_a = {{14{s_reg[17]}}, s_reg};
        mul_b = {{2{m_reg[16]}}, m_reg};
      end
      mcwo_pkg::ST_BLEND: begin
        mul_a = {{13{diff[18]}}, diff};
        mul_b = {12'b0, mod_depth};
      end
      mcwo_pkg::ST_DIVA: begin
        mul_a = {8'b0, ax_full[23:0]};
        mul_b = {1'b0, mcwo_pkg::RECIP_127};
      end
      mcwo_pkg::ST_VOL: begin
        mul_a = {{14{s_reg[17]}}, s_reg};
        mul_b = {12'b0, volume_level};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign empty    = !out_valid;
  assign out_load = (state == mcwo_pkg::ST_OUT) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcwo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    case (state)
      mcwo_pkg::ST_IDLE: begin
        if (q_nempty) begin
          q_rd = 1'b1;
          if (q_entry.op == mcwo_pkg::OP_SAMPLE) begin
            if (wave_is_sine || (mod_depth != 7'd0)) begin
              state_next = mcwo_pkg::ST_ZZ;
            end else begin
              state_next = mcwo_pkg::ST_VOL;
            end
          end
        end
      end
      mcwo_pkg::ST_ZZ:   state_next = mcwo_pkg::ST_T1;
      mcwo_pkg::ST_T1:   state_next = mcwo_pkg::ST_T2;
      mcwo_pkg::ST_T2:   state_next = mcwo_pkg::ST_TR;
      mcwo_pkg::ST_TR:   state_next = mcwo_pkg::ST_TQ;
      mcwo_pkg::ST_TQ: begin
        if (sine_sel) begin
          state_next = mcwo_pkg::ST_RING;
        end else if (mod_depth != 7'd0) begin
          state_next = mcwo_pkg::ST_ZZ;
        end else begin
          state_next = mcwo_pkg::ST_VOL;
        end
      end
      mcwo_pkg::ST_RING:  state_next = mcwo_pkg::ST_BLEND;
      mcwo_pkg::ST_BLEND: state_next = mcwo_pkg::ST_DIVA;
      mcwo_pkg::ST_DIVA:  state_next = mcwo_pkg::ST_DIVB;
      mcwo_pkg::ST_DIVB:  state_next = div_sel ? mcwo_pkg::ST_OUT : mcwo_pkg::ST_VOL;
      mcwo_pkg::ST_VOL:   state_next = mcwo_pkg::ST_DIVA;
      mcwo_pkg::ST_OUT: begin
        if (!out_valid || pop) begin
          state_next = mcwo_pkg::ST_IDLE;
        end
      end
      default: state_next = mcwo_pkg::ST_IDLE;
    endcase
  end

  // Settings, phases and result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_phase     <= '0;
      mod_phase      <= '0;
      note_number    <= mcwo_pkg::NOTE_RESET;
      wave_select    <= mcwo_pkg::WAVE_SINE;
      pulse_level    <= mcwo_pkg::PULSE_RESET;
      mod_depth      <= '0;
      volume_level   <= mcwo_pkg::VOLUME_RESET;
      program_number <= '0;
      out_valid      <= 1'b0;
    end else begin
      if ((state == mcwo_pkg::ST_IDLE) && q_nempty) begin
        case (q_entry.op)
          mcwo_pkg::OP_WAVE:    wave_select    <= mcwo_pkg::wave_t'(q_entry.val[1:0]);
          mcwo_pkg::OP_PULSE:   pulse_level    <= q_entry.val;
          mcwo_pkg::OP_DEPTH:   mod_depth      <= q_entry.val;
          mcwo_pkg::OP_VOLUME:  volume_level   <= q_entry.val;
          mcwo_pkg::OP_NOTE:    note_number    <= q_entry.val;
          mcwo_pkg::OP_PROGRAM: program_number <= q_entry.val;
          default: ;
        endcase
      end
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid  <= 1'b1;
        main_phase <= main_phase + inc_tab[note_number];
        mod_phase  <= mod_phase + minc_tab[note_number];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      mcwo_pkg::ST_ZZ,
      mcwo_pkg::ST_T2,
      mcwo_pkg::ST_TR,
      mcwo_pkg::ST_RING,
      mcwo_pkg::ST_BLEND,
      mcwo_pkg::ST_VOL:  prod <= mul_a * mul_b;
      mcwo_pkg::ST_T1: begin
        prod   <= mul_a * mul_b;
        z2_reg <= prod[32:16];
      end
      mcwo_pkg::ST_DIVA: begin
        prod     <= mul_a * mul_b;
        ax_reg   <= ax_full[23:0];
        xneg_reg <= x_val[24];
      end
      default: ;
    endcase

    if ((state == mcwo_pkg::ST_IDLE) && q_nempty) begin
      div_sel <= 1'b0;
      if (wave_is_sine) begin
        z_reg    <= fold_main.z;
        neg_reg  <= fold_main.neg;
        sine_sel <= 1'b0;
      end else begin
        s_reg    <= wave_val;
        z_reg    <= fold_mod.z;
        neg_reg  <= fold_mod.neg;
        sine_sel <= 1'b1;
      end
    end

    if (state == mcwo_pkg::ST_TQ) begin
      if (sine_sel) begin
        m_reg <= sine_val;
      end else begin
        s_reg    <= {sine_val[16], sine_val};
        z_reg    <= fold_mod.z;
        neg_reg  <= fold_mod.neg;
        sine_sel <= 1'b1;
      end
    end

    if (state == mcwo_pkg::ST_VOL) begin
      div_sel <= 1'b1;
    end

    if (state == mcwo_pkg::ST_DIVB) begin
      s_reg <= div_sel ? vol_sat : blend_sum[17:0];
    end

    if (out_load) begin
      sample_out <= s_reg[15:0];
    end
  end

endmodule

`default_nettype wire

### rtl/mcwo_checker.sv
// Port-level checker for the oscillator core, bound to the top level.
`default_nettype none

`include "midi_controlled_wave_oscillator_core_assert.svh"

module mcwo_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               action,
  input logic [7:0]         status_byte,
  input logic [6:0]         data_one,
  input logic [6:0]         data_two,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] sample_out
);

  // Sample transactions accepted but not yet delivered.
  logic [3:0] pending;
  logic       in_sample;
  logic       out_take;

  assign in_sample = push && !full && action;
  assign out_take  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_sample, out_take})
        2'b10:   pending <= pending + 4'd1;
        2'b01:   pending <= pending - 4'd1;
        default: pending <= pending;
      endcase
    end
  end

  `MCWO_ASSERT_AFTER_RESET(a_reset_clears, empty && !full, "queues not empty after reset")
  `MCWO_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(sample_out), "stalled result changed")
  `MCWO_ASSERT_NOW(a_no_invented, empty || (pending != 4'd0), "result without a sample transaction")
  `MCWO_ASSERT_NOW(a_bounded, pending <= 4'(mcwo_pkg::QDEPTH + 2), "more samples in flight than storage")

endmodule

bind midi_controlled_wave_oscillator_core mcwo_checker u_chk (.*);

`default_nettype wire

### bench/midi_controlled_wave_oscillator_core_tb.sv
// Testbench for the MIDI controlled wave oscillator: queue handshakes, predicted samples.
module midi_controlled_wave_oscillator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcwo_pkg::*;

  // Tuning of the oscillator as the bench sees it; kept apart from the RTL package
  // so that a wrong constant there shows up as a mismatch.
  localparam longint unsigned RATE_HZ    = 48000;
  localparam longint unsigned SINE_STEPS = 1024;
  localparam longint unsigned INV_2PI    = 683565276;  // 2^32 / (2*pi)
  localparam longint unsigned POLY_A     = 1686629713; // quarter-wave sine, Q30
  localparam longint unsigned POLY_B     = 688904866;
  localparam longint unsigned POLY_C     = 76016977;

  localparam logic signed [15:0] Q15_MIN = 16'sh8000;

  localparam int NUM_DIRECTED   = 26;
  localparam int RANDOM_CHUNK   = 300;  // live items per random phase, three phases
  localparam int FLOOD_ITEMS    = 16;   // samples offered while the receiver holds off
  localparam int HOLD_CYCLES    = 150;  // length of the receiver hold-off
  localparam int SETTLE_CYCLES  = 40;   // idle wait after the output side has drained
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic action = 1'b0;
  logic [7:0] status_byte = 8'h00;
  logic [6:0] data_one = 7'd0;
  logic [6:0] data_two = 7'd0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] sample_out;

  midi_controlled_wave_oscillator_core uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .status_byte(status_byte),
    .data_one(data_one),
    .data_two(data_two),
    .empty(empty),
    .pop(pop),
    .sample_out(sample_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Oscillator state as the bench predicts it
  // ---------------------------------------------------------------------------
  logic [31:0] tone_phase;
  logic [31:0] ring_phase;
  int          cur_note;
  wave_t       cur_wave;
  int          cur_pulse;
  int          cur_depth;
  int          cur_volume;
  int          cur_program;

  // Samples predicted for accepted ticks, oldest first.
  logic signed [15:0] pending_samples[$];

  int  errors = 0;
  int  samples_checked = 0;
  int  midi_applied = 0;
  int  stalled_cycles = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;        // both sides skip their idle gaps while set
  bit  hold_request = 1'b0;  // asks the receiver for one long hold-off

  task automatic reset_model();
    tone_phase  = '0;
    ring_phase  = '0;
    cur_note    = 69;
    cur_wave    = WAVE_SINE;
    cur_pulse   = 64;
    cur_depth   = 0;
    cur_volume  = 64;
    cur_program = 0;
  endtask

  // Octave-zero frequency of each pitch class, Q16.16 Hz.
  function automatic longint unsigned octave_base(input int pitch_class);
    case (pitch_class)
      0:  return 535809;
      1:  return 567670;
      2:  return 601425;
      3:  return 637188;
      4:  return 675077;
      5:  return 715219;
      6:  return 757749;
      7:  return 802807;
      8:  return 850544;
      9:  return 901120;
      10: return 954703;
      default: return 1011473;
    endcase
  endfunction

  // Phase step per sample: shift the octave-zero entry up by the octave and
  // move from Q16.16 Hz into cycle units of 2^-32, rounding half up.
  function automatic longint unsigned tone_step();
    longint unsigned base;
    int shift;
    base  = octave_base(cur_note % 12);
    shift = cur_note / 12 + 16;
    return ((base << shift) + RATE_HZ / 2) / RATE_HZ;
  endfunction

  // sin(pi/2 * z) for z in Q0.16 on a quarter wave, result Q1.15.
  function automatic longint quarter_poly(input longint unsigned z);
    longint unsigned z2, t1, t2, t3, r, q;
    z2 = (z * z) >> 16;
    t1 = (POLY_C * z2) >> 16;
    t2 = ((POLY_B - t1) * z2) >> 16;
    t3 = POLY_A - t2;
    r  = (t3 * z) >> 16;
    q  = (r + 16384) >> 15;
    if (q > 32767) q = 32767;
    return longint'(q);
  endfunction

  // Full sine from a Q0.16 phase: quantize to the table depth, fold into a
  // quarter, mirror on odd quarters and negate the second half.
  function automatic longint sin_lookup(input logic [15:0] frac);
    longint unsigned fu, idx, a, z;
    logic [1:0] quad;
    longint v;
    fu   = frac;
    idx  = (fu * SINE_STEPS) >> 16;
    a    = ((idx * 65536) / SINE_STEPS) & 64'hFFFF;
    quad = 2'(a >> 14);
    z    = (a & 64'h3FFF) << 2;
    if (quad[0]) z = 65536 - z;
    v = quarter_poly(z);
    return quad[1] ? -v : v;
  endfunction

  // Produce one sample from the current settings and advance both phases.
  function automatic logic signed [15:0] render_sample();
    longint unsigned step, ring_step, f16u;
    longint s, m, p;
    step      = tone_step();
    ring_step = (((step >> 16) * INV_2PI) + (((step & 64'hFFFF) * INV_2PI) >> 16)) >> 16;
    f16u      = tone_phase[31:16];
    s = 0;
    // A nonzero program mutes the waveform; the blend and volume still run.
    if (cur_program == 0) begin
      case (cur_wave)
        WAVE_SINE: s = sin_lookup(tone_phase[31:16]);
        WAVE_TRI:  s = (f16u < 32768) ? longint'(f16u) : 32768 - longint'(f16u);
        WAVE_SAW:  s = longint'(f16u) - 32768;
        default:   s = (f16u * 127 > longint'(cur_pulse) * 65536) ? 32767 : -32768;
      endcase
    end
    // Blend toward the ring-modulated copy; the product is floored, the
    // depth scaling truncates toward zero.
    if (cur_depth != 0) begin
      m = sin_lookup(ring_phase[31:16]);
      p = (s * m) >>> 15;
      s = s + ((p - s) * cur_depth) / 127;
    end
    s = (s * cur_volume) / 127;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    tone_phase = tone_phase + 32'(step);
    ring_phase = ring_phase + 32'(ring_step);
    return 16'(s);
  endfunction

  // Apply one MIDI message; report whether it touches any setting.
  function automatic bit apply_midi(input logic [7:0] status, input logic [6:0] first,
                                    input logic [6:0] second);
    bit live;
    live = 1'b0;
    // Control changes count only on the exact status, channel zero.
    if (status == STATUS_CC) begin
      live = 1'b1;
      case (first[3:0])
        CC_WAVE:   cur_wave = wave_t'(2'((int'(second) * 3) / 127));
        CC_PULSE:  cur_pulse = second;
        CC_DEPTH:  cur_depth = second;
        CC_VOLUME: cur_volume = second;
        default:   live = 1'b0;
      endcase
    end
    // Note-off retunes and program change stores, on any channel.
    if (status[7:4] == TYPE_NOTE_OFF) begin
      cur_note = first;
      live = 1'b1;
    end
    if (status[7:4] == TYPE_PROGRAM) begin
      cur_program = first;
      live = 1'b1;
    end
    return live;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: offer one transaction, hold it until accepted, then predict
  // ---------------------------------------------------------------------------
  task automatic offer(input logic tick, input logic [7:0] status, input logic [6:0] first,
                       input logic [6:0] second, input bit known,
                       input logic signed [15:0] want, output bit live);
    int gap;
    logic signed [15:0] predicted;
    gap = steady ? 0 : $urandom_range(0, 11);
    // Drop push only for a real gap, so back-to-back transactions keep it high.
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    action      <= tick;
    status_byte <= status;
    data_one    <= first;
    data_two    <= second;
    do begin
      @(posedge clk);
      if (full) stalled_cycles++;
    end while (full);
    if (tick) begin
      predicted = render_sample();
      // A typed value replaces the prediction; the model state still advances.
      pending_samples.push_back(known ? want : predicted);
      live = 1'b1;
    end else begin
      live = apply_midi(status, first, second);
      if (live) midi_applied++;
    end
  endtask

  // Random traffic until the given number of non-ignored transactions went in.
  // Mostly well-formed control changes, note-offs and samples; the rest is noise.
  task automatic random_phase(input int goal);
    int   done_live, count, pick;
    bit   live;
    logic tick;
    logic [7:0] st;
    logic [6:0] first, second;
    logic [3:0] ctl;
    done_live = 0;
    count = 0;
    while (done_live < goal) begin
      // Switch idling on and off in stretches.
      if (count % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      count++;
      pick   = $urandom_range(0, 99);
      tick   = 1'b0;
      st     = 8'($urandom);
      first  = 7'($urandom);
      second = 7'($urandom);
      if (pick < 45) begin
        // Sample tick; the MIDI fields carry junk that must be ignored.
        tick = 1'b1;
      end else if (pick < 70) begin
        st = STATUS_CC;
        case ($urandom_range(0, 3))
          0:       ctl = CC_WAVE;
          1:       ctl = CC_PULSE;
          2:       ctl = CC_DEPTH;
          default: ctl = CC_VOLUME;
        endcase
        // Keep the upper controller bits random; they must not matter.
        if ($urandom_range(0, 9) != 0) first = {first[6:4], ctl};
        // Favor zero depth now and then so the plain path stays exercised.
        if (ctl == CC_DEPTH && $urandom_range(0, 2) == 0) second = 7'd0;
      end else if (pick < 80) begin
        st = {TYPE_NOTE_OFF, st[3:0]};
      end else if (pick < 88) begin
        st = {TYPE_PROGRAM, st[3:0]};
        // Mostly program zero, or the output would sit in silence.
        if ($urandom_range(0, 3) != 0) first = 7'd0;
      end
      offer(tick, st, first, second, 1'b0, 16'sd0, live);
      if (live) done_live++;
    end
    steady = 1'b0;
  endtask

  // Hold off the receiver and keep offering samples back to back, so that the
  // result queue and the command queue fill and full rises.
  task automatic flood_while_held();
    bit live;
    hold_request = 1'b1;
    steady = 1'b1;
    repeat (FLOOD_ITEMS)
      offer(1'b1, 8'($urandom), 7'($urandom), 7'($urandom), 1'b0, 16'sd0, live);
    steady = 1'b0;
  endtask

  // Hold the input idle until every predicted sample came out, then settle.
  task automatic drain(input int settle);
    push <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Directed rows. The expected sample is typed in only where it is plain:
  // silence at phase zero, the square stuck low, a muted program, zero volume.
  typedef struct packed {
    logic               is_tick;
    logic [7:0]         status;
    logic [6:0]         first;
    logic [6:0]         second;
    logic               known;
    logic signed [15:0] want;
  } stim_row_t;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // sine at phase zero right after reset
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b1, 16'sd0},
    // square, full volume, pulse at its top: never above the threshold
    '{1'b0, STATUS_CC, 7'(CC_WAVE), CTRL_MAX, 1'b0, 16'sd0},
    '{1'b0, STATUS_CC, 7'(CC_VOLUME), CTRL_MAX, 1'b0, 16'sd0},
    '{1'b0, STATUS_CC, 7'(CC_PULSE), CTRL_MAX, 1'b0, 16'sd0},
    '{1'b1, 8'hFF, 7'h7F, 7'h7F, 1'b1, Q15_MIN},
    // pulse zero through controller 18, which folds onto the pulse control
    '{1'b0, STATUS_CC, {3'b001, CC_PULSE}, 7'd0, 1'b0, 16'sd0},
    // a tick whose fields look like a volume change
    '{1'b1, STATUS_CC, 7'(CC_VOLUME), 7'd0, 1'b0, 16'sd0},
    // lowest controller value that picks triangle
    '{1'b0, STATUS_CC, 7'(CC_WAVE), WAVE_STEP1, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b0, 16'sd0},
    // lowest value that picks saw, via controller 113
    '{1'b0, STATUS_CC, {3'b111, CC_WAVE}, WAVE_STEP2, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b0, 16'sd0},
    // top note on the last channel: the largest phase step
    '{1'b0, {TYPE_NOTE_OFF, 4'hF}, 7'd127, 7'd0, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b0, 16'sd0},
    // bottom note
    '{1'b0, {TYPE_NOTE_OFF, 4'h0}, 7'd0, 7'd127, 1'b0, 16'sd0},
    // control change on channel one and on an unused controller: both ignored
    '{1'b0, 8'hB1, 7'(CC_VOLUME), 7'd0, 1'b0, 16'sd0},
    '{1'b0, STATUS_CC, 7'h7F, 7'd0, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b0, 16'sd0},
    // full ring depth, and the highest value that still picks sine
    '{1'b0, STATUS_CC, 7'(CC_DEPTH), CTRL_MAX, 1'b0, 16'sd0},
    '{1'b0, STATUS_CC, 7'(CC_WAVE), WAVE_STEP1 - 7'd1, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b0, 16'sd0},
    // nonzero program mutes even with the ring blend on
    '{1'b0, {TYPE_PROGRAM, 4'hF}, 7'd127, 7'd0, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b1, 16'sd0},
    // back to program zero, volume zero mutes
    '{1'b0, {TYPE_PROGRAM, 4'h0}, 7'd0, 7'd0, 1'b0, 16'sd0},
    '{1'b0, STATUS_CC, 7'(CC_VOLUME), 7'd0, 1'b0, 16'sd0},
    '{1'b1, 8'h00, 7'd0, 7'd0, 1'b1, 16'sd0}
  };

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit live;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      offer(directed_rows[i].is_tick, directed_rows[i].status, directed_rows[i].first,
            directed_rows[i].second, directed_rows[i].known, directed_rows[i].want, live);

    random_phase(RANDOM_CHUNK);
    flood_while_held();
    random_phase(RANDOM_CHUNK);
    // Pause the input until the output side caught up completely.
    drain(SETTLE_CYCLES);
    random_phase(RANDOM_CHUNK);
    drain(SETTLE_CYCLES);

    $display("run covered %0d checked samples and %0d setting changes",
             samples_checked, midi_applied);
    $display("input stalled on full for %0d cycles; all waves, notes, ring and mute paths hit",
             stalled_cycles);
    if (errors == 0)
      $display("PASS midi_controlled_wave_oscillator_core");
    else
      $display("FAIL midi_controlled_wave_oscillator_core");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: pop with random gaps, compare against the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    logic signed [15:0] want;
    wait (!rst);
    forever begin
      if (hold_request) begin
        // One long hold-off, counted here, while the sender keeps pushing.
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t unexpected sample: expected none actual %0d", $time, sample_out);
      end else begin
        want = pending_samples.pop_front();
        samples_checked++;
        if (sample_out !== want) begin
          errors++;
          $display("%0t sample_out mismatch: expected %0d actual %0d",
                   $time, want, sample_out);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles, %0d samples outstanding",
               $time, quiet_cycles, pending_samples.size());
      $display("FAIL midi_controlled_wave_oscillator_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mcwo_pkg.sv
rtl/mcwo_queue.sv
rtl/mcwo_front.sv
rtl/mcwo_back.sv
rtl/midi_controlled_wave_oscillator_core.sv
rtl/mcwo_checker.sv
bench/midi_controlled_wave_oscillator_core_tb.sv
